FILE: src/bsfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfe_pkg
// Shared types and constants for the byte stream frame extractor.
// ----------------------------------------------------------------------------
package bsfe_pkg;

  // Default sizes, overridable through the top-level parameters
  localparam int MAX_CHUNK_DEF    = 2048;
  localparam int MARKER_BYTES_DEF = 8;

  // Fixed field widths
  localparam int LEN_W   = 4;
  localparam int FLEN_W  = 12;
  localparam int REG_W   = 64;
  localparam int ADDR_W  = 6;

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // Output byte kinds
  typedef enum logic [1:0] {
    KIND_FRAME = 2'd0,
    KIND_RUN   = 2'd1,
    KIND_PASS  = 2'd2
  } kind_t;

  // Register index (byte address / 8)
  typedef enum logic [2:0] {
    REG_ENABLE       = 3'd0,
    REG_FIXED_MODE   = 3'd1,
    REG_FRAME_LENGTH = 3'd2,
    REG_START_MARKER = 3'd3,
    REG_START_LEN    = 3'd4,
    REG_END_MARKER   = 3'd5,
    REG_END_LEN      = 3'd6
  } reg_idx_t;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic              enable;
    logic              fixed_mode;
    logic [FLEN_W-1:0] frame_length;
    logic [REG_W-1:0]  start_marker;
    logic [LEN_W-1:0]  start_len;
    logic [REG_W-1:0]  end_marker;
    logic [LEN_W-1:0]  end_len;
  } cfg_t;

  // Work for the back end from one input byte: an optional single byte,
  // then a burst of held start-marker bytes
  typedef struct packed {
    logic             first_vld;
    logic [7:0]       first_byte;
    logic             first_last;
    kind_t            first_kind;
    logic [LEN_W-1:0] burst_len;
  } job_t;

endpackage

FILE: src/bsfe_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfe stream interfaces
// Valid/ready channels for received bytes and emitted bytes.
// ----------------------------------------------------------------------------
interface bsfe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       chunk_end;

  modport source (output valid, data_byte, chunk_end, input ready);
  modport sink   (input valid, data_byte, chunk_end, output ready);
endinterface

interface bsfe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic [1:0] out_kind;

  modport source (output valid, out_byte, out_last, out_kind, input ready);
  modport sink   (input valid, out_byte, out_last, out_kind, output ready);
endinterface

FILE: src/bsfe_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfe_cfg
// APB register file; any write to a defined register also pulses clear.
// ----------------------------------------------------------------------------
module bsfe_cfg import bsfe_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [REG_W-1:0]  pwdata,
  output logic [REG_W-1:0]  prdata,
  output logic              pready,
  output cfg_t              cfg,
  output logic              clear
);

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else begin
      if (wr) begin
        unique case (idx)
          REG_ENABLE:       cfg.enable       <= pwdata[0];
          REG_FIXED_MODE:   cfg.fixed_mode   <= pwdata[0];
          REG_FRAME_LENGTH: cfg.frame_length <= pwdata[FLEN_W-1:0];
          REG_START_MARKER: cfg.start_marker <= pwdata;
          REG_START_LEN:    cfg.start_len    <= pwdata[LEN_W-1:0];
          REG_END_MARKER:   cfg.end_marker   <= pwdata;
          REG_END_LEN:      cfg.end_len      <= pwdata[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Framing state drops at the same edge that writes the register
  always_comb begin
    clear = 1'b0;
    if (wr) begin
      unique case (idx) inside
        REG_ENABLE, REG_FIXED_MODE, REG_FRAME_LENGTH, REG_START_MARKER,
        REG_START_LEN, REG_END_MARKER, REG_END_LEN: clear = 1'b1;
        default:                                    clear = 1'b0;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_ENABLE:       prdata = REG_W'(cfg.enable);
      REG_FIXED_MODE:   prdata = REG_W'(cfg.fixed_mode);
      REG_FRAME_LENGTH: prdata = REG_W'(cfg.frame_length);
      REG_START_MARKER: prdata = cfg.start_marker;
      REG_START_LEN:    prdata = REG_W'(cfg.start_len);
      REG_END_MARKER:   prdata = cfg.end_marker;
      REG_END_LEN:      prdata = REG_W'(cfg.end_len);
      default:          prdata = '0;
    endcase
  end

endmodule

FILE: src/bsfe_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfe_front
// Accepts one byte per cycle while the job queue is not full, runs the framing state and pushes at most one job.
// ----------------------------------------------------------------------------
module bsfe_front import bsfe_pkg::*; #(
  parameter int MAX_CHUNK    = MAX_CHUNK_DEF,
  parameter int MARKER_BYTES = MARKER_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cfg_t                        cfg,
  input  logic                        clear,
  input  logic                        in_valid,
  input  logic [7:0]                  in_byte,
  input  logic                        in_end,
  output logic                        in_ready,
  input  logic                        q_full,
  output logic                        push,
  output job_t                        push_job,
  output logic [8*MARKER_BYTES-1:0]   push_data
);

  localparam int CW = $clog2(MAX_CHUNK + 1);
  localparam int FW = $clog2(MARKER_BYTES + 1);

  typedef logic [MARKER_BYTES-1:0][7:0] win_t;

  // Framing state
  win_t          hunt, hunt_next;
  win_t          tail, tail_next;
  logic [FW-1:0] fill, fill_next;
  logic          in_frame, in_frame_next;
  logic [CW-1:0] count, count_next;

  logic [FW-1:0] sl, el;
  logic          accept;

  // Push one byte into a window of n bytes
  function automatic win_t shift_win(win_t w, logic [FW-1:0] f, logic [FW-1:0] n,
                                     logic [7:0] b);
    win_t r;
    win_t ws;
    ws = w >> 8;
    r  = '0;
    for (int i = 0; i < MARKER_BYTES; i++) begin
      if (f >= n) begin
        if (FW'(i) + 1'b1 < n)       r[i] = ws[i];
        else if (FW'(i) + 1'b1 == n) r[i] = b;
      end else begin
        r[i] = (FW'(i) == f) ? b : w[i];
      end
    end
    return r;
  endfunction

  // Low n bytes of the window equal the marker
  function automatic logic win_hit(win_t w, logic [REG_W-1:0] mk, logic [FW-1:0] n);
    logic ok;
    ok = 1'b1;
    for (int i = 0; i < MARKER_BYTES; i++) begin
      if (FW'(i) < n && w[i] != mk[8*i +: 8]) ok = 1'b0;
    end
    return ok;
  endfunction

  // Marker lengths clamped to the window size
  assign sl = (cfg.start_len > LEN_W'(MARKER_BYTES)) ? FW'(MARKER_BYTES) : FW'(cfg.start_len);
  assign el = (cfg.end_len > LEN_W'(MARKER_BYTES)) ? FW'(MARKER_BYTES) : FW'(cfg.end_len);

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  // Classify the byte and compute the next framing state
  always_comb begin
    logic          framed, lst, hit, had, cut, enter;
    logic [CW-1:0] cinc, cnt;
    logic [FW-1:0] fl, fill_new;
    win_t          tw, win_new;

    hunt_next     = hunt;
    tail_next     = tail;
    fill_next     = fill;
    in_frame_next = in_frame;
    count_next    = count;
    push_job      = '0;
    push_data     = '0;
    framed = 1'b0; lst = 1'b0; hit = 1'b0; had = 1'b0; cut = 1'b0; enter = 1'b0;
    cinc = '0; cnt = '0; fl = '0; fill_new = '0; tw = '0; win_new = '0;

    if (!cfg.enable) begin
      // passthrough
      push_job.first_vld  = 1'b1;
      push_job.first_byte = in_byte;
      push_job.first_last = in_end;
      push_job.first_kind = KIND_PASS;
    end else if (cfg.fixed_mode || (sl == '0 && el == '0)) begin
      // fixed length or chunk-end runs
      framed = cfg.fixed_mode && cfg.frame_length != '0;
      cinc   = count + 1'b1;
      lst    = (32'(cinc) >= MAX_CHUNK) ||
               (framed ? (32'(cinc) == 32'(cfg.frame_length)) : in_end);
      count_next          = lst ? '0 : cinc;
      push_job.first_vld  = 1'b1;
      push_job.first_byte = in_byte;
      push_job.first_last = lst;
      push_job.first_kind = framed ? KIND_FRAME : KIND_RUN;
    end else if (!in_frame && sl != '0) begin
      // hunting for a start marker; oldest held byte leaves as a run byte
      had      = fill >= sl;
      win_new  = shift_win(hunt, fill, sl, in_byte);
      fill_new = had ? sl : fill + 1'b1;
      hit      = fill_new >= sl && win_hit(win_new, cfg.start_marker, sl);
      hunt_next = win_new;
      fill_next = fill_new;
      if (had) begin
        cinc = count + 1'b1;
        lst  = hit || 32'(cinc) >= MAX_CHUNK;
        count_next          = lst ? '0 : cinc;
        push_job.first_vld  = 1'b1;
        push_job.first_byte = hunt[0];
        push_job.first_last = lst;
        push_job.first_kind = KIND_RUN;
      end
      if (hit) begin
        in_frame_next = 1'b1;
        count_next    = '0;
        if (el != '0) begin
          // start marker opens the frame: release it as frame bytes
          push_job.burst_len = LEN_W'(sl);
          push_data          = win_new;
          count_next         = CW'(sl);
          hunt_next          = '0;
          fill_next          = '0;
          tail_next          = '0;
        end
      end
    end else if (el != '0) begin
      // inside a frame, searching for the end marker
      enter    = !in_frame;
      tw       = enter ? '0 : tail;
      fl       = enter ? '0 : fill;
      cnt      = enter ? '0 : count;
      cinc     = cnt + 1'b1;
      win_new  = shift_win(tw, fl, el, in_byte);
      fill_new = (fl >= el) ? el : fl + 1'b1;
      hit      = fill_new >= el && win_hit(win_new, cfg.end_marker, el);
      lst      = hit || 32'(cinc) >= MAX_CHUNK;
      push_job.first_vld  = 1'b1;
      push_job.first_byte = in_byte;
      push_job.first_last = lst;
      push_job.first_kind = KIND_FRAME;
      if (lst) begin
        hunt_next     = '0;
        tail_next     = '0;
        fill_next     = '0;
        in_frame_next = 1'b0;
        count_next    = '0;
      end else begin
        hunt_next     = enter ? '0 : hunt;
        tail_next     = win_new;
        fill_next     = fill_new;
        in_frame_next = 1'b1;
        count_next    = cinc;
      end
    end else begin
      // start marker only: frame ends before the next start marker
      had      = fill >= sl;
      win_new  = shift_win(hunt, fill, sl, in_byte);
      fill_new = had ? sl : fill + 1'b1;
      cnt      = had ? count + 1'b1 : count;
      hit      = fill_new >= sl && 32'(cnt) >= 32'(sl) &&
                 win_hit(win_new, cfg.start_marker, sl);
      hunt_next  = win_new;
      fill_next  = fill_new;
      count_next = cnt;
      if (had) begin
        cut = 32'(cnt) >= MAX_CHUNK;
        push_job.first_vld  = 1'b1;
        push_job.first_byte = hunt[0];
        push_job.first_last = hit || cut;
        push_job.first_kind = KIND_FRAME;
        if (hit || cut) begin
          count_next    = '0;
          in_frame_next = 1'b0;
        end
      end
      if (hit) begin
        in_frame_next = 1'b1;
        count_next    = '0;
      end
    end
  end

  assign push = accept && (push_job.first_vld || push_job.burst_len != '0);

  // State registers
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      hunt     <= '0;
      tail     <= '0;
      fill     <= '0;
      in_frame <= 1'b0;
      count    <= '0;
    end else if (accept) begin
      hunt     <= hunt_next;
      tail     <= tail_next;
      fill     <= fill_next;
      in_frame <= in_frame_next;
      count    <= count_next;
    end
  end

endmodule

FILE: src/bsfe_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfe_queue
// Small job FIFO in flops between the front and back ends.
// ----------------------------------------------------------------------------
module bsfe_queue import bsfe_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] head,
  output logic             empty,
  output logic             full
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PW-1:0]    wptr, rptr;
  logic [NW-1:0]    used;

  assign empty = used == '0;
  assign full  = used == NW'(QUEUE_DEPTH);
  assign head  = mem[rptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      used <= '0;
    end else begin
      if (push) wptr <= (32'(wptr) == QUEUE_DEPTH - 1) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (32'(rptr) == QUEUE_DEPTH - 1) ? '0 : rptr + 1'b1;
      if (push && !pop)      used <= used + 1'b1;
      else if (pop && !push) used <= used - 1'b1;
    end
  end

endmodule

FILE: src/bsfe_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfe_back
// Walks the head job byte by byte into a registered output stage.
// ----------------------------------------------------------------------------
module bsfe_back import bsfe_pkg::*; #(
  parameter int MARKER_BYTES = MARKER_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  job_t                      job,
  input  logic [8*MARKER_BYTES-1:0] job_data,
  input  logic                      q_empty,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_byte,
  output logic                      out_last,
  output logic [1:0]                out_kind
);

  localparam int KW = $clog2(MARKER_BYTES + 2);

  logic [KW-1:0] k;
  logic [KW-1:0] total, bidx;
  logic          load, at_end, is_first;
  logic [7:0]    sel_byte;

  assign total    = KW'(job.first_vld) + KW'(job.burst_len);
  assign is_first = job.first_vld && k == '0;
  assign bidx     = k - KW'(job.first_vld);
  assign at_end   = k == total - 1'b1;
  assign load     = !q_empty && (!out_valid || out_ready);
  assign pop      = load && at_end;

  // Burst byte select
  always_comb begin
    sel_byte = '0;
    for (int i = 0; i < MARKER_BYTES; i++) begin
      if (bidx == KW'(i)) sel_byte = job_data[8*i +: 8];
    end
  end

  // Position within the head job
  always_ff @(posedge clk) begin
    if (rst)       k <= '0;
    else if (load) k <= at_end ? '0 : k + 1'b1;
  end

  // Output stage
  always_ff @(posedge clk) begin
    if (rst)            out_valid <= 1'b0;
    else if (load)      out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= is_first ? job.first_byte : sel_byte;
      out_last <= is_first ? job.first_last : 1'b0;
      out_kind <= is_first ? job.first_kind : KIND_FRAME;
    end
  end

endmodule

FILE: src/byte_stream_frame_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// byte_stream_frame_extractor
// Cuts a received byte stream into tagged frames and runs.
// ----------------------------------------------------------------------------
// The block takes one byte per clock on din while din.ready is high and
// emits tagged bytes on dout. Every accepted byte is classified
// combinationally by the front end and turned into a job of zero to
// MARKER_BYTES+1 output bytes; the back end drains jobs at one byte per cycle
// through a registered output stage while dout is ready. Sustained rate is one
// byte per cycle while dout is ready; a byte that completes a start marker
// while an end marker is set yields up to MARKER_BYTES+1 output bytes. The
// four-entry job queue takes further jobs while that burst drains; once it is
// full, din.ready drops until the burst has drained. Configuration writes go
// through the APB port and reset all framing state; the user must make them
// only while the block is idle, which the block itself does not enforce.
module byte_stream_frame_extractor import bsfe_pkg::*; #(
  parameter int MAX_CHUNK    = MAX_CHUNK_DEF,
  parameter int MARKER_BYTES = MARKER_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  bsfe_in_if.sink           din,
  bsfe_out_if.source        dout,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [REG_W-1:0]  pwdata,
  output logic [REG_W-1:0]  prdata,
  output logic              pready
);

  localparam int DW = 8 * MARKER_BYTES;
  localparam int JW = $bits(job_t) + DW;

  cfg_t             cfg;
  logic             clear;
  logic             push, pop, q_empty, q_full;
  job_t             push_job, head_job;
  logic [DW-1:0]    push_data, head_data;
  logic [JW-1:0]    head;

  // Registers
  bsfe_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .clear   (clear)
  );

  // Front end: classify and update framing state
  bsfe_front #(
    .MAX_CHUNK    (MAX_CHUNK),
    .MARKER_BYTES (MARKER_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .clear     (clear),
    .in_valid  (din.valid),
    .in_byte   (din.data_byte),
    .in_end    (din.chunk_end),
    .in_ready  (din.ready),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job),
    .push_data (push_data)
  );

  // Job queue
  bsfe_queue #(
    .WIDTH (JW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({push_job, push_data}),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign head_job  = job_t'(head[JW-1:DW]);
  assign head_data = head[DW-1:0];

  // Back end: emit bytes
  bsfe_back #(
    .MARKER_BYTES (MARKER_BYTES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (head_job),
    .job_data  (head_data),
    .q_empty   (q_empty),
    .pop       (pop),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .out_byte  (dout.out_byte),
    .out_last  (dout.out_last),
    .out_kind  (dout.out_kind)
  );

endmodule

FILE: src/bsfe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsfe_checker
// Port-level checks for the frame extractor, bound to the top level.
// ----------------------------------------------------------------------------
module bsfe_checker import bsfe_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic [1:0] out_kind
);

  // Nothing leaves the output stage right after reset
  a_reset_idle: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // Queue is empty after reset, so input must be ready
  a_reset_ready: assert property (@(posedge clk) $past(rst) |-> in_ready)
    else $error("input not ready right after reset");

  // Only defined kinds are emitted
  a_kind_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_kind == KIND_FRAME || out_kind == KIND_RUN ||
                   out_kind == KIND_PASS))
    else $error("undefined output kind");

  // A stalled output transfer holds valid and payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
                                $stable(out_last) && $stable(out_kind))
    else $error("stalled output changed");

endmodule

bind byte_stream_frame_extractor bsfe_checker u_bsfe_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (din.ready),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .out_byte  (dout.out_byte),
  .out_last  (dout.out_last),
  .out_kind  (dout.out_kind)
);

FILE: tb/tb_byte_stream_frame_extractor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_stream_frame_extractor
// Self-checking bench for the byte stream frame extractor. A clocked driver
// feeds received bytes from a queue and predicts the tagged output bytes of
// each accepted transfer. A clocked monitor compares every output transfer
// with the oldest prediction. Both sides idle at random. Registers are
// rewritten between phases: passthrough, fixed-length, unframed, and the
// marker modes.
// ----------------------------------------------------------------------------
module tb_byte_stream_frame_extractor;
  import bsfe_pkg::*;

  localparam int CHUNK_CAP     = MAX_CHUNK_DEF;
  localparam int MARKER_CAP    = MARKER_BYTES_DEF;
  // Extra pause once every predicted output has been seen
  localparam int SETTLE_CYCLES = 24;
  // ~130 bytes; each can cost a maximal input gap plus up to nine outputs
  // behind maximal output stalls, with register writes on top; the limit
  // leaves ample margin over that
  localparam int CYCLE_LIMIT   = 200_000;
  localparam int MAX_REPORTS   = 40;

  typedef enum int {
    MODE_PASS, MODE_FIXED, MODE_PLAIN, MODE_START_END, MODE_START_ONLY, MODE_END_ONLY
  } frame_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       ce;
  } rx_byte_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    kind_t      kind;
  } tagged_byte_t;

  typedef struct {
    logic [63:0] win;
    int          fill;
    bit          fell;
    logic [7:0]  ev;
  } shift_res_t;

  logic clk;
  logic rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [REG_W-1:0]  pwdata;
  logic [REG_W-1:0]  prdata;
  logic              pready;

  bsfe_in_if  din_if ();
  bsfe_out_if dout_if ();

  byte_stream_frame_extractor u_dut (
    .clk     (clk),
    .rst     (rst),
    .din     (din_if),
    .dout    (dout_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Stimulus and prediction stores
  rx_byte_t     rx_q[$];
  tagged_byte_t tagged_q[$];
  rx_byte_t     drv_item;

  int  errors;
  int  accepted;
  int  checked;
  int  phases;
  int  queued;
  int  cycles;
  int  drv_gap;
  int  mon_stall;
  bit  drv_calm;
  bit  mon_calm;

  // Shadow configuration
  logic        cfg_en;
  logic        cfg_fixed;
  logic [11:0] cfg_flen;
  logic [63:0] cfg_smark;
  logic [3:0]  cfg_slen;
  logic [63:0] cfg_emark;
  logic [3:0]  cfg_elen;

  // Shadow framing state
  logic [63:0] hunt_win;
  int          win_fill;
  bit          in_frm;
  int          chunk_cnt;
  logic [63:0] tail_win;

  // Clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d outputs outstanding", cycles, tagged_q.size());
      $display("FAIL byte_stream_frame_extractor");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic logic [63:0] octet_mask(int n);
    if (n <= 0) return 64'd0;
    if (n >= 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic int clamp_len(logic [3:0] v);
    return (v > MARKER_CAP) ? MARKER_CAP : int'(v);
  endfunction

  // Push a byte into a window of len bytes; the oldest byte falls out when full
  function automatic shift_res_t window_shift(logic [63:0] win, int fill, int len,
                                              logic [7:0] b);
    shift_res_t r;
    r.fell = 1'b0;
    r.ev   = 8'd0;
    if (fill >= len) begin
      r.ev   = win[7:0];
      r.win  = ((win >> 8) | ({56'd0, b} << (8 * (len - 1)))) & octet_mask(len);
      r.fill = len;
      r.fell = 1'b1;
    end else begin
      r.win  = win | ({56'd0, b} << (8 * fill));
      r.fill = fill + 1;
    end
    return r;
  endfunction

  function automatic void clear_framing();
    hunt_win  = 64'd0;
    win_fill  = 0;
    in_frm    = 1'b0;
    chunk_cnt = 0;
    tail_win  = 64'd0;
  endfunction

  function automatic void emit(logic [7:0] b, logic last, kind_t kind);
    tagged_byte_t t;
    t.data = b;
    t.last = last;
    t.kind = kind;
    tagged_q.push_back(t);
  endfunction

  // Expected tagged bytes for one received byte
  task automatic frame_step(logic [7:0] b, logic ce);
    int          sl;
    int          el;
    logic [63:0] m;
    shift_res_t  sr;
    bit          match;
    bit          last;
    bit          framed;
    bit          cut;
    sl = clamp_len(cfg_slen);
    el = clamp_len(cfg_elen);
    if (!cfg_en) begin
      emit(b, ce, KIND_PASS);
      return;
    end
    // fixed length, or no marker at all: count toward length or chunk end
    if (cfg_fixed || (sl == 0 && el == 0)) begin
      framed = cfg_fixed && (cfg_flen != 12'd0);
      chunk_cnt++;
      last = (chunk_cnt >= CHUNK_CAP) || (framed ? (chunk_cnt == int'(cfg_flen)) : ce);
      if (last) chunk_cnt = 0;
      emit(b, last, framed ? KIND_FRAME : KIND_RUN);
      return;
    end
    // hunting for a start marker
    if (!in_frm) begin
      if (sl == 0) begin
        clear_framing();
        in_frm = 1'b1;
      end else begin
        m  = octet_mask(sl);
        sr = window_shift(hunt_win, win_fill, sl, b);
        hunt_win = sr.win;
        win_fill = sr.fill;
        match = (win_fill >= sl) && ((hunt_win & m) == (cfg_smark & m));
        if (sr.fell) begin
          chunk_cnt++;
          last = match || (chunk_cnt >= CHUNK_CAP);
          emit(sr.ev, last, KIND_RUN);
          if (last) chunk_cnt = 0;
        end
        if (match) begin
          in_frm    = 1'b1;
          chunk_cnt = 0;
          if (el > 0) begin
            // held start marker goes out at the head of the frame
            for (int i = 0; i < sl; i++) emit(hunt_win[8*i +: 8], 1'b0, KIND_FRAME);
            chunk_cnt = sl;
            hunt_win  = 64'd0;
            win_fill  = 0;
            tail_win  = 64'd0;
          end
        end
        return;
      end
    end
    // open frame closed by the end marker
    if (el > 0) begin
      m = octet_mask(el);
      chunk_cnt++;
      sr = window_shift(tail_win, win_fill, el, b);
      tail_win = sr.win;
      win_fill = sr.fill;
      match = (win_fill >= el) && ((tail_win & m) == (cfg_emark & m));
      last  = match || (chunk_cnt >= CHUNK_CAP);
      emit(b, last, KIND_FRAME);
      if (last) clear_framing();
      return;
    end
    // start marker only: frame ends just before the next start marker
    m  = octet_mask(sl);
    sr = window_shift(hunt_win, win_fill, sl, b);
    hunt_win = sr.win;
    win_fill = sr.fill;
    if (sr.fell) chunk_cnt++;
    match = (win_fill >= sl) && (chunk_cnt >= sl) && ((hunt_win & m) == (cfg_smark & m));
    if (sr.fell) begin
      cut = chunk_cnt >= CHUNK_CAP;
      emit(sr.ev, match || cut, KIND_FRAME);
      if (match || cut) begin
        chunk_cnt = 0;
        in_frm    = 1'b0;
      end
    end
    if (match) begin
      in_frm    = 1'b1;
      chunk_cnt = 0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Idle patterns: mostly short, a few long, with calm stretches
  // --------------------------------------------------------------------------
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Input driver: one transfer per handshake, predicts on acceptance
  always @(posedge clk) begin
    if (rst) begin
      din_if.valid <= 1'b0;
    end else begin
      if ($urandom_range(0, 149) == 0) drv_calm = !drv_calm;
      if (din_if.valid && din_if.ready) begin
        frame_step(din_if.data_byte, din_if.chunk_end);
        accepted++;
      end
      if (!din_if.valid || din_if.ready) begin
        if (drv_gap > 0) begin
          drv_gap--;
          din_if.valid <= 1'b0;
        end else if (rx_q.size() > 0) begin
          drv_item = rx_q.pop_front();
          din_if.valid     <= 1'b1;
          din_if.data_byte <= drv_item.data;
          din_if.chunk_end <= drv_item.ce;
          drv_gap = pick_gap(drv_calm);
        end else begin
          din_if.valid <= 1'b0;
        end
      end
    end
  end

  // Output compare against the oldest prediction
  task automatic check_tagged(logic [7:0] b, logic last, logic [1:0] kind);
    tagged_byte_t e;
    if (tagged_q.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: unexpected output byte %02h last %0b kind %0d", $time, b, last, kind);
      return;
    end
    e = tagged_q.pop_front();
    checked++;
    if (b !== e.data) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: out_byte expected %02h actual %02h", $time, e.data, b);
    end
    if (last !== e.last) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: out_last expected %0b actual %0b (byte %02h)", $time, e.last, last,
                 e.data);
    end
    if (kind !== e.kind) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: out_kind expected %0d actual %0d (byte %02h)", $time, e.kind, kind,
                 e.data);
    end
  endtask

  // Output monitor with random backpressure
  always @(posedge clk) begin
    if (rst) begin
      dout_if.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 149) == 0) mon_calm = !mon_calm;
      if (dout_if.valid && dout_if.ready)
        check_tagged(dout_if.out_byte, dout_if.out_last, dout_if.out_kind);
      if (mon_stall > 0) begin
        mon_stall--;
        dout_if.ready <= 1'b0;
      end else begin
        dout_if.ready <= 1'b1;
        mon_stall = pick_gap(mon_calm);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Configuration and stimulus helpers
  // --------------------------------------------------------------------------
  task automatic reg_write(reg_idx_t idx, logic [63:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ENABLE:       cfg_en    = val[0];
      REG_FIXED_MODE:   cfg_fixed = val[0];
      REG_FRAME_LENGTH: cfg_flen  = val[11:0];
      REG_START_MARKER: cfg_smark = val;
      REG_START_LEN:    cfg_slen  = val[3:0];
      REG_END_MARKER:   cfg_emark = val;
      REG_END_LEN:      cfg_elen  = val[3:0];
      default: ;
    endcase
    // every write drops held bytes and framing state
    clear_framing();
  endtask

  task automatic set_cfg(logic en, logic fx, logic [11:0] flen, logic [63:0] smark,
                         logic [3:0] slen, logic [63:0] emark, logic [3:0] elen);
    reg_write(REG_ENABLE, {63'd0, en});
    reg_write(REG_FIXED_MODE, {63'd0, fx});
    reg_write(REG_FRAME_LENGTH, {52'd0, flen});
    reg_write(REG_START_MARKER, smark);
    reg_write(REG_START_LEN, {60'd0, slen});
    reg_write(REG_END_MARKER, emark);
    reg_write(REG_END_LEN, {60'd0, elen});
  endtask

  task automatic send(logic [7:0] b, logic ce);
    rx_byte_t it;
    it.data = b;
    it.ce   = ce;
    rx_q.push_back(it);
    queued++;
  endtask

  function automatic logic rand_ce();
    return ($urandom_range(0, 3) == 0);
  endfunction

  task automatic send_rand();
    send(8'($urandom_range(0, 255)), rand_ce());
  endtask

  task automatic send_marker(logic [63:0] mk, int len);
    for (int i = 0; i < len; i++) send(mk[8*i +: 8], rand_ce());
  endtask

  // Wait until every byte is accepted and every output seen, then settle
  task automatic finish_phase();
    while (!(rx_q.size() == 0 && !din_if.valid && tagged_q.size() == 0)) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    phases++;
  endtask

  function automatic logic [3:0] pick_mlen();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return 4'($urandom_range(1, 4));
    if (r < 9) return 4'($urandom_range(5, 8));
    return 4'($urandom_range(9, 15));
  endfunction

  function automatic logic [63:0] pick_marker();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 64'd0;
    if (r == 1) return '1;
    return {$urandom, $urandom};
  endfunction

  function automatic logic [11:0] pick_flen();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 12'd0;
    if (r < 8) return 12'($urandom_range(1, 9));
    return 12'($urandom_range(0, 4095));
  endfunction

  // One random phase: random mode and registers, then mostly well-formed frames
  task automatic random_phase();
    frame_mode_t mode;
    logic [63:0] smark;
    logic [63:0] emark;
    logic [3:0]  slen;
    logic [3:0]  elen;
    int          sl;
    int          el;
    int          target;
    int          start_cnt;
    mode   = frame_mode_t'($urandom_range(0, 5));
    smark  = pick_marker();
    emark  = pick_marker();
    slen   = pick_mlen();
    elen   = pick_mlen();
    target = $urandom_range(13, 17);
    case (mode)
      MODE_PASS:       set_cfg(1'b0, 1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)),
                               smark, 4'($urandom_range(0, 15)), emark,
                               4'($urandom_range(0, 15)));
      MODE_FIXED:      set_cfg(1'b1, 1'b1, pick_flen(), smark, slen, emark, elen);
      MODE_PLAIN:      set_cfg(1'b1, 1'b0, 12'($urandom_range(0, 4095)), smark, 4'd0,
                               emark, 4'd0);
      MODE_START_END:  set_cfg(1'b1, 1'b0, pick_flen(), smark, slen, emark, elen);
      MODE_START_ONLY: set_cfg(1'b1, 1'b0, pick_flen(), smark, slen, emark, 4'd0);
      default:         set_cfg(1'b1, 1'b0, pick_flen(), smark, 4'd0, emark, elen);
    endcase
    sl = clamp_len(cfg_slen);
    el = clamp_len(cfg_elen);
    start_cnt = queued;
    while (queued - start_cnt < target) begin
      if (cfg_fixed || !cfg_en || (sl == 0 && el == 0)) begin
        send_rand();
      end else if ($urandom_range(0, 9) < 7) begin
        // noise, start marker, payload, end marker
        repeat ($urandom_range(0, 3)) send_rand();
        if (sl > 0) send_marker(cfg_smark, sl);
        repeat ($urandom_range(0, 6)) send_rand();
        if (el > 0) send_marker(cfg_emark, el);
      end else begin
        // broken: a marker cut short, then noise
        if (sl > 1 && $urandom_range(0, 1)) send_marker(cfg_smark, $urandom_range(1, sl - 1));
        else if (el > 1) send_marker(cfg_emark, $urandom_range(1, el - 1));
        repeat ($urandom_range(1, 4)) send_rand();
      end
    end
    finish_phase();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    din_if.valid = 1'b0;
    din_if.data_byte = 8'd0;
    din_if.chunk_end = 1'b0;
    dout_if.ready = 1'b0;
    errors = 0;
    accepted = 0;
    checked = 0;
    phases = 0;
    queued = 0;
    cycles = 0;
    drv_gap = 0;
    mon_stall = 0;
    drv_calm = 1'b0;
    mon_calm = 1'b0;
    cfg_en = 1'b0;
    cfg_fixed = 1'b0;
    cfg_flen = 12'd0;
    cfg_smark = 64'd0;
    cfg_slen = 4'd0;
    cfg_emark = 64'd0;
    cfg_elen = 4'd0;
    clear_framing();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset state is passthrough: chunk end copies to last
    send(8'h00, 1'b0);
    send(8'hFF, 1'b1);
    send(8'hA5, 1'b0);
    finish_phase();

    // fixed frames of two bytes, chunk end has no effect
    set_cfg(1'b1, 1'b1, 12'd2, 64'd0, 4'd0, 64'd0, 4'd0);
    send(8'h00, 1'b0);
    send(8'hFF, 1'b1);
    send(8'h80, 1'b0);
    finish_phase();

    // start length above the cap acts as eight bytes; chunk end while hunting
    set_cfg(1'b1, 1'b0, 12'd0, 64'h0123_4567_89AB_CDEF, 4'd9, 64'h0000_0000_0000_0A0D,
            4'd2);
    send(8'h55, 1'b1);
    send(8'h00, 1'b0);
    send_marker(cfg_smark, 8);
    send(8'hFF, 1'b0);
    send(8'h0D, 1'b1);
    send(8'h0A, 1'b0);
    finish_phase();

    // start marker only, with back-to-back overlapping markers
    set_cfg(1'b1, 1'b0, 12'd0, 64'h0000_0000_0000_7E7E, 4'd2, '1, 4'd0);
    send(8'h11, 1'b0);
    send(8'h7E, 1'b0);
    send(8'h7E, 1'b1);
    send(8'h7E, 1'b0);
    send(8'h22, 1'b0);
    send(8'h7E, 1'b0);
    send(8'h7E, 1'b0);
    finish_phase();

    // random phases
    repeat (6) random_phase();

    if (tagged_q.size() != 0) begin
      errors++;
      $display("%0t: %0d predicted output bytes never arrived", $time, tagged_q.size());
    end
    $display("run covered %0d received bytes over %0d register settings", accepted, phases);
    $display("%0d tagged output bytes compared, %0d mismatches", checked, errors);
    if (errors == 0) begin
      $display("PASS byte_stream_frame_extractor");
    end else begin
      $display("FAIL byte_stream_frame_extractor");
    end
    $finish;
  end

endmodule
